FILE: src/crcfr_pkg.sv
// Shared types, codes and the CRC-16/MODBUS byte step for the framed receiver.
// No dependencies; used by every module of the block.
`default_nettype none

package crcfr_pkg;

  localparam int BUFFER_DEPTH_DEF = 256;
  localparam int QUEUE_DEPTH_DEF  = 4;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;
  localparam logic [15:0] LEN_MIN  = 16'd3;

  localparam logic [7:0] RST_HDR_FIRST  = 8'hAA;
  localparam logic [7:0] RST_HDR_SECOND = 8'h55;
  localparam logic [7:0] RST_TIMEOUT    = 8'd10;

  // configuration register indexes
  localparam logic [1:0] CFG_HDR_FIRST  = 2'd0;
  localparam logic [1:0] CFG_HDR_SECOND = 2'd1;
  localparam logic [1:0] CFG_TIMEOUT    = 2'd2;

  // input actions
  localparam logic [1:0] ACT_BYTE = 2'd0;
  localparam logic [1:0] ACT_TICK = 2'd1;
  localparam logic [1:0] ACT_READ = 2'd2;

  // frame status codes
  localparam logic [1:0] ST_MATCH      = 2'd0;
  localparam logic [1:0] ST_MISMATCH   = 2'd1;
  localparam logic [1:0] ST_LEN_REJECT = 2'd2;

  // result kinds
  localparam logic KIND_REPORT = 1'b0;
  localparam logic KIND_READ   = 1'b1;

  typedef enum logic [1:0] {
    OP_WRITE,
    OP_READ,
    OP_REPORT
  } op_t;

  typedef struct packed {
    op_t         op;
    logic [1:0]  status;
    logic [7:0]  addr;
    logic [7:0]  func;
    logic [15:0] len;
    logic [15:0] crc_comp;
    logic [15:0] crc_recv;
    logic [7:0]  index;
    logic [7:0]  data;
  } cmd_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

FILE: src/crcfr_front.sv
// Front end: configuration registers, frame parser, CRC and timeout.
// Turns accepted items into commands for the back end. Uses crcfr_pkg.
`default_nettype none

module crcfr_front (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_we,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [7:0]         cfg_data,
  input  wire logic               push,
  input  wire logic               q_full,
  input  wire logic [1:0]         action,
  input  wire logic [7:0]         rx_byte,
  input  wire logic [7:0]         read_index,
  output logic                    enq,
  output crcfr_pkg::cmd_t         cmd
);

  logic [7:0]  header_first;
  logic [7:0]  header_second;
  logic [7:0]  timeout_ticks;

  logic [8:0]  byte_position, byte_position_next;
  logic [15:0] frame_length, frame_length_next;
  logic [15:0] running_crc, running_crc_next;
  logic [15:0] received_crc, received_crc_next;
  logic [7:0]  address_byte, address_byte_next;
  logic [7:0]  func_byte, func_byte_next;
  logic        timeout_armed, timeout_armed_next;
  logic [7:0]  idle_ticks, idle_ticks_next;

  logic        accept;
  logic [15:0] crc_upd;
  logic [15:0] new_len;
  logic [8:0]  pos_inc;
  logic [8:0]  lim_data;
  logic [7:0]  idle_inc;

  always_ff @(posedge clk) begin
    if (rst) begin
      header_first  <= crcfr_pkg::RST_HDR_FIRST;
      header_second <= crcfr_pkg::RST_HDR_SECOND;
      timeout_ticks <= crcfr_pkg::RST_TIMEOUT;
    end else if (cfg_we) begin
      case (cfg_index)
        crcfr_pkg::CFG_HDR_FIRST:  header_first  <= cfg_data;
        crcfr_pkg::CFG_HDR_SECOND: header_second <= cfg_data;
        crcfr_pkg::CFG_TIMEOUT:    timeout_ticks <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= '0;
      frame_length  <= '0;
      running_crc   <= crcfr_pkg::CRC_INIT;
      received_crc  <= '0;
      address_byte  <= '0;
      func_byte     <= '0;
      timeout_armed <= 1'b0;
      idle_ticks    <= '0;
    end else begin
      byte_position <= byte_position_next;
      frame_length  <= frame_length_next;
      running_crc   <= running_crc_next;
      received_crc  <= received_crc_next;
      address_byte  <= address_byte_next;
      func_byte     <= func_byte_next;
      timeout_armed <= timeout_armed_next;
      idle_ticks    <= idle_ticks_next;
    end
  end

  assign accept   = push && !q_full;
  assign crc_upd  = crcfr_pkg::crc_byte((byte_position == 9'd2) ? crcfr_pkg::CRC_INIT
                                                                 : running_crc, rx_byte);
  assign new_len  = {frame_length[15:8], rx_byte};
  assign pos_inc  = byte_position + 9'd1;
  // last data position; length is 3..255 once past position 4
  assign lim_data = {1'b0, frame_length[7:0]} + 9'd2;
  assign idle_inc = (idle_ticks == 8'hFF) ? idle_ticks : idle_ticks + 8'd1;

  always_comb begin
    byte_position_next = byte_position;
    frame_length_next  = frame_length;
    running_crc_next   = running_crc;
    received_crc_next  = received_crc;
    address_byte_next  = address_byte;
    func_byte_next     = func_byte;
    timeout_armed_next = timeout_armed;
    idle_ticks_next    = idle_ticks;
    enq                = 1'b0;
    cmd                = '0;
    cmd.op             = crcfr_pkg::OP_WRITE;

    if (accept) begin
      case (action)
        crcfr_pkg::ACT_BYTE: begin
          idle_ticks_next = '0;
          if (byte_position == 9'd0) begin
            if (rx_byte == header_first) begin
              byte_position_next = 9'd1;
            end
          end else if (byte_position == 9'd1) begin
            if (rx_byte == header_second) begin
              byte_position_next = 9'd2;
              timeout_armed_next = 1'b1;
            end else begin
              byte_position_next = 9'd0;
            end
          end else if (byte_position == 9'd2) begin
            address_byte_next  = rx_byte;
            running_crc_next   = crc_upd;
            byte_position_next = 9'd3;
          end else if (byte_position == 9'd3) begin
            frame_length_next  = {rx_byte, frame_length[7:0]};
            running_crc_next   = crc_upd;
            byte_position_next = 9'd4;
          end else if (byte_position == 9'd4) begin
            frame_length_next = new_len;
            running_crc_next  = crc_upd;
            if (new_len[15:8] != 8'd0 || new_len < crcfr_pkg::LEN_MIN) begin
              byte_position_next = 9'd0;
              enq                = 1'b1;
              cmd.op             = crcfr_pkg::OP_REPORT;
              cmd.status         = crcfr_pkg::ST_LEN_REJECT;
              cmd.addr           = address_byte;
              cmd.len            = new_len;
            end else begin
              byte_position_next = 9'd5;
            end
          end else begin
            if (byte_position <= lim_data) begin
              enq              = 1'b1;
              cmd.op           = crcfr_pkg::OP_WRITE;
              cmd.index        = 8'(byte_position - 9'd5);
              cmd.data         = rx_byte;
              running_crc_next = crc_upd;
              if (byte_position == 9'd5) begin
                func_byte_next = rx_byte;
              end
            end else if (byte_position == lim_data + 9'd1) begin
              received_crc_next = {rx_byte, received_crc[7:0]};
            end else if (byte_position == lim_data + 9'd2) begin
              received_crc_next = {received_crc[15:8], rx_byte};
            end
            if (pos_inc >= lim_data + 9'd5) begin
              byte_position_next = 9'd0;
              enq                = 1'b1;
              cmd.op             = crcfr_pkg::OP_REPORT;
              cmd.status         = (running_crc == received_crc) ? crcfr_pkg::ST_MATCH
                                                                 : crcfr_pkg::ST_MISMATCH;
              cmd.addr           = address_byte;
              cmd.func           = func_byte;
              cmd.len            = frame_length;
              cmd.crc_comp       = running_crc;
              cmd.crc_recv       = received_crc;
            end else begin
              byte_position_next = pos_inc;
            end
          end
        end
        crcfr_pkg::ACT_TICK: begin
          if (timeout_armed) begin
            if (idle_inc >= timeout_ticks) begin
              timeout_armed_next = 1'b0;
              idle_ticks_next    = '0;
              byte_position_next = 9'd0;
            end else begin
              idle_ticks_next = idle_inc;
            end
          end
        end
        crcfr_pkg::ACT_READ: begin
          enq       = 1'b1;
          cmd.op    = crcfr_pkg::OP_READ;
          cmd.index = read_index;
        end
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: src/crcfr_queue.sv
// Command queue between front and back end; DEPTH of 2 or more entries.
// Uses crcfr_pkg for the command type.
`default_nettype none

module crcfr_queue #(
  parameter int DEPTH = crcfr_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             enq,
  input  wire crcfr_pkg::cmd_t  enq_cmd,
  input  wire logic             deq,
  output logic                  full,
  output logic                  empty,
  output crcfr_pkg::cmd_t       head
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  crcfr_pkg::cmd_t slots [DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [CW-1:0]   count;
  logic            do_enq;
  logic            do_deq;

  assign full   = (count == CW'(DEPTH));
  assign empty  = (count == '0);
  assign head   = slots[rd_ptr];
  assign do_enq = enq && !full;
  assign do_deq = deq && !empty;

  always_ff @(posedge clk) begin
    if (do_enq) begin
      slots[wr_ptr] <= enq_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_enq) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (do_deq) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      case ({do_enq, do_deq})
        2'b10:   count <= count + CW'(1);
        2'b01:   count <= count - CW'(1);
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: src/crcfr_back.sv
// Back end: payload store with per-entry valid bits, read stage, result register.
// Executes queued commands in order. Uses crcfr_pkg.
`default_nettype none

module crcfr_back #(
  parameter int BUFFER_DEPTH = crcfr_pkg::BUFFER_DEPTH_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             q_empty,
  input  wire crcfr_pkg::cmd_t  q_head,
  output logic                  q_pop,
  input  wire logic             pop,
  output logic                  out_valid,
  output logic                  result_kind,
  output logic [1:0]            frame_status,
  output logic [7:0]            slave_address,
  output logic [7:0]            function_code,
  output logic [15:0]           length_field,
  output logic [15:0]           crc_computed,
  output logic [15:0]           crc_received,
  output logic [7:0]            read_data
);

  // index field is 8 bits, so only the first 256 entries are reachable
  localparam int STORE_DEPTH = (BUFFER_DEPTH < 256) ? BUFFER_DEPTH : 256;
  localparam int AW          = $clog2(STORE_DEPTH);

  logic [7:0]             mem [STORE_DEPTH];
  logic [STORE_DEPTH-1:0] vld;

  logic            s1_valid;
  crcfr_pkg::cmd_t s1_cmd;
  logic [7:0]      mem_q;
  logic            vld_q;

  logic            adv;
  logic            s1_free;
  logic            head_is_wr;
  logic            in_range;
  logic [AW-1:0]   addr;

  assign adv        = s1_valid && (!out_valid || pop);
  assign s1_free    = !s1_valid || adv;
  assign head_is_wr = (q_head.op == crcfr_pkg::OP_WRITE);
  assign q_pop      = !q_empty && (head_is_wr || s1_free);
  assign in_range   = ({24'd0, q_head.index} < 32'(BUFFER_DEPTH));
  assign addr       = q_head.index[AW-1:0];

  always_ff @(posedge clk) begin
    if (q_pop && head_is_wr && in_range) begin
      mem[addr] <= q_head.data;
    end
    if (q_pop && !head_is_wr) begin
      mem_q  <= mem[addr];
      vld_q  <= in_range && vld[addr];
      s1_cmd <= q_head;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (q_pop && head_is_wr && in_range) begin
      vld[addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (q_pop && !head_is_wr) begin
      s1_valid <= 1'b1;
    end else if (adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (s1_cmd.op == crcfr_pkg::OP_READ) begin
        result_kind   <= crcfr_pkg::KIND_READ;
        frame_status  <= '0;
        slave_address <= '0;
        function_code <= '0;
        length_field  <= '0;
        crc_computed  <= '0;
        crc_received  <= '0;
        read_data     <= vld_q ? mem_q : 8'd0;
      end else begin
        result_kind   <= crcfr_pkg::KIND_REPORT;
        frame_status  <= s1_cmd.status;
        slave_address <= s1_cmd.addr;
        function_code <= s1_cmd.func;
        length_field  <= s1_cmd.len;
        crc_computed  <= s1_cmd.crc_comp;
        crc_received  <= s1_cmd.crc_recv;
        read_data     <= '0;
      end
    end
  end

endmodule

`default_nettype wire

FILE: src/crc16_framed_packet_receiver.sv
// Top level of the CRC-16/MODBUS framed packet receiver.
// Instantiates crcfr_front, crcfr_queue and crcfr_back; uses crcfr_pkg.
//
//   channel  | handshake            | payload
//   ---------+----------------------+-------------------------------------------
//   input    | push / full          | action, rx_byte, read_index
//   result   | empty / pop          | result_kind, frame_status, slave_address,
//            |                      | function_code, length_field, crc_computed,
//            |                      | crc_received, read_data
//   config   | cfg_we (no wait)     | cfg_index, cfg_data
//
// One item per cycle while full is low; the parser and its unrolled CRC byte step
// are combinational. Results go through the queue, read stage and result register.
// full rises once the QUEUE_DEPTH-entry command queue fills behind a stalled result.
// Reset is synchronous; payload store valid bits clear at once, no clearing pass.
`default_nettype none

module crc16_framed_packet_receiver #(
  parameter int BUFFER_DEPTH = crcfr_pkg::BUFFER_DEPTH_DEF,
  parameter int QUEUE_DEPTH  = crcfr_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [7:0]  cfg_data,
  input  wire logic        push,
  output logic             full,
  input  wire logic [1:0]  action,
  input  wire logic [7:0]  rx_byte,
  input  wire logic [7:0]  read_index,
  output logic             empty,
  input  wire logic        pop,
  output logic             result_kind,
  output logic [1:0]       frame_status,
  output logic [7:0]       slave_address,
  output logic [7:0]       function_code,
  output logic [15:0]      length_field,
  output logic [15:0]      crc_computed,
  output logic [15:0]      crc_received,
  output logic [7:0]       read_data
);

  logic            q_full;
  logic            q_empty;
  logic            q_enq;
  logic            q_pop;
  crcfr_pkg::cmd_t q_in;
  crcfr_pkg::cmd_t q_head;
  logic            out_valid;

  assign full  = q_full;
  assign empty = !out_valid;

  crcfr_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .push       (push),
    .q_full     (q_full),
    .action     (action),
    .rx_byte    (rx_byte),
    .read_index (read_index),
    .enq        (q_enq),
    .cmd        (q_in)
  );

  crcfr_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .enq     (q_enq),
    .enq_cmd (q_in),
    .deq     (q_pop),
    .full    (q_full),
    .empty   (q_empty),
    .head    (q_head)
  );

  crcfr_back #(
    .BUFFER_DEPTH (BUFFER_DEPTH)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .q_empty       (q_empty),
    .q_head        (q_head),
    .q_pop         (q_pop),
    .pop           (pop),
    .out_valid     (out_valid),
    .result_kind   (result_kind),
    .frame_status  (frame_status),
    .slave_address (slave_address),
    .function_code (function_code),
    .length_field  (length_field),
    .crc_computed  (crc_computed),
    .crc_received  (crc_received),
    .read_data     (read_data)
  );

  a_no_enq_when_full : assert property (@(posedge clk) disable iff (rst)
    q_enq |-> !q_full)
    else $error("command queued while queue full");

  a_read_fields_zero : assert property (@(posedge clk) disable iff (rst)
    (!empty && result_kind == crcfr_pkg::KIND_READ) |->
      (frame_status == 2'd0 && length_field == 16'd0 && crc_computed == 16'd0 &&
       crc_received == 16'd0 && slave_address == 8'd0 && function_code == 8'd0))
    else $error("read item carries report fields");

  a_reject_fields : assert property (@(posedge clk) disable iff (rst)
    (!empty && result_kind == crcfr_pkg::KIND_REPORT &&
     frame_status == crcfr_pkg::ST_LEN_REJECT) |->
      (crc_computed == 16'd0 && crc_received == 16'd0 && function_code == 8'd0 &&
       read_data == 8'd0))
    else $error("rejected frame report carries crc or function data");

  a_report_no_data : assert property (@(posedge clk) disable iff (rst)
    (!empty && result_kind == crcfr_pkg::KIND_REPORT) |->
      (read_data == 8'd0 && frame_status != 2'd3))
    else $error("bad frame report item");

endmodule

`default_nettype wire

FILE: test/crc16_framed_packet_receiver_check.sv
`timescale 1ns / 100ps
// Checker for crc16_framed_packet_receiver: mirrors the frame parser, the CRC-16/MODBUS
// accumulator and the payload store, and compares every popped result with the oldest
// predicted one. Depends on crcfr_pkg for codes and reset values.

module crc16_framed_packet_receiver_check (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [7:0]  cfg_data,
  input  wire logic        push,
  input  wire logic        full,
  input  wire logic [1:0]  action,
  input  wire logic [7:0]  rx_byte,
  input  wire logic [7:0]  read_index,
  input  wire logic        empty,
  input  wire logic        pop,
  input  wire logic        result_kind,
  input  wire logic [1:0]  frame_status,
  input  wire logic [7:0]  slave_address,
  input  wire logic [7:0]  function_code,
  input  wire logic [15:0] length_field,
  input  wire logic [15:0] crc_computed,
  input  wire logic [15:0] crc_received,
  input  wire logic [7:0]  read_data,
  output int               fail_count,
  output int               results_due
);

  localparam logic [15:0] MODBUS_INIT = 16'hFFFF;
  localparam logic [15:0] MODBUS_POLY = 16'hA001;
  localparam int          STORE_DEPTH = 256;
  localparam int          LEN_LIMIT   = 256;

  typedef struct packed {
    logic        kind;
    logic [1:0]  status;
    logic [7:0]  addr;
    logic [7:0]  func;
    logic [15:0] len;
    logic [15:0] crc_comp;
    logic [15:0] crc_recv;
    logic [7:0]  data;
  } rx_result_t;

  logic [7:0]  sync_first;
  logic [7:0]  sync_second;
  logic [7:0]  abort_ticks;
  logic [15:0] frame_pos;
  logic [15:0] len_seen;
  logic [15:0] crc_run;
  logic [15:0] crc_frame;
  logic [7:0]  addr_seen;
  logic [7:0]  payload_mem [STORE_DEPTH];
  logic        armed;
  logic [7:0]  idle_count;
  rx_result_t  results_q [$];
  int          mismatches = 0;

  assign fail_count = mismatches;

  function automatic logic [15:0] modbus_step(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    int k;
    c = crc ^ {8'h00, b};
    for (k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ MODBUS_POLY) : (c >> 1);
    end
    return c;
  endfunction

  function automatic void clear_mirror();
    int i;
    sync_first  = crcfr_pkg::RST_HDR_FIRST;
    sync_second = crcfr_pkg::RST_HDR_SECOND;
    abort_ticks = crcfr_pkg::RST_TIMEOUT;
    frame_pos   = '0;
    len_seen    = '0;
    crc_run     = MODBUS_INIT;
    crc_frame   = '0;
    addr_seen   = '0;
    armed       = 1'b0;
    idle_count  = '0;
    for (i = 0; i < STORE_DEPTH; i++) begin
      payload_mem[i] = '0;
    end
    results_q.delete();
  endfunction

  function automatic void queue_report(input logic [1:0] status, input logic [7:0] func);
    rx_result_t r;
    r        = '0;
    r.kind   = crcfr_pkg::KIND_REPORT;
    r.status = status;
    r.addr   = addr_seen;
    r.func   = func;
    r.len    = len_seen;
    if (status != crcfr_pkg::ST_LEN_REJECT) begin
      r.crc_comp = crc_run;
      r.crc_recv = crc_frame;
    end
    results_q.push_back(r);
  endfunction

  function automatic void take_rx_byte(input logic [7:0] b);
    int p;
    int l;
    p = frame_pos;
    l = len_seen;
    idle_count = '0;
    case (p)
      0: begin
        if (b == sync_first) frame_pos = 16'd1;
      end
      1: begin
        if (b == sync_second) begin
          frame_pos = 16'd2;
          armed = 1'b1;
        end else begin
          frame_pos = '0;
        end
      end
      2: begin
        addr_seen = b;
        crc_run   = modbus_step(MODBUS_INIT, b);
        frame_pos = 16'd3;
      end
      3: begin
        len_seen[15:8] = b;
        crc_run        = modbus_step(crc_run, b);
        frame_pos      = 16'd4;
      end
      4: begin
        len_seen[7:0] = b;
        crc_run       = modbus_step(crc_run, b);
        if (len_seen >= LEN_LIMIT || len_seen < crcfr_pkg::LEN_MIN) begin
          frame_pos = '0;
          queue_report(crcfr_pkg::ST_LEN_REJECT, 8'h00);
        end else begin
          frame_pos = 16'd5;
        end
      end
      default: begin
        if (p <= l + 2) begin
          if (p - 5 < STORE_DEPTH) payload_mem[p - 5] = b;
          crc_run = modbus_step(crc_run, b);
        end else if (p == l + 3) begin
          crc_frame[15:8] = b;
        end else if (p == l + 4) begin
          crc_frame[7:0] = b;
        end
        p++;
        if (p >= l + 7) begin
          frame_pos = '0;
          queue_report((crc_run == crc_frame) ? crcfr_pkg::ST_MATCH
                                              : crcfr_pkg::ST_MISMATCH, payload_mem[0]);
        end else begin
          frame_pos = p[15:0];
        end
      end
    endcase
  endfunction

  function automatic void parse_item(input logic [1:0] act, input logic [7:0] b,
                                     input logic [7:0] idx);
    rx_result_t r;
    r = '0;
    case (act)
      crcfr_pkg::ACT_BYTE: take_rx_byte(b);
      crcfr_pkg::ACT_TICK: begin
        if (armed) begin
          if (idle_count != 8'hFF) idle_count++;
          if (idle_count >= abort_ticks) begin
            armed      = 1'b0;
            idle_count = '0;
            frame_pos  = '0;
          end
        end
      end
      crcfr_pkg::ACT_READ: begin
        r.kind = crcfr_pkg::KIND_READ;
        r.data = payload_mem[idx];
        results_q.push_back(r);
      end
      default: ;
    endcase
  endfunction

  function automatic void check_field(input string name, input logic [15:0] want,
                                      input logic [15:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0h got %0h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  function automatic void check_result();
    rx_result_t want;
    if (results_q.size() == 0) begin
      $display("%0t: result with none expected: kind %0h status %0h data %0h", $time,
               result_kind, frame_status, read_data);
      mismatches++;
    end else begin
      want = results_q.pop_front();
      check_field("result_kind", want.kind, result_kind);
      check_field("frame_status", want.status, frame_status);
      check_field("slave_address", want.addr, slave_address);
      check_field("function_code", want.func, function_code);
      check_field("length_field", want.len, length_field);
      check_field("crc_computed", want.crc_comp, crc_computed);
      check_field("crc_received", want.crc_recv, crc_received);
      check_field("read_data", want.data, read_data);
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      clear_mirror();
    end else begin
      if (pop && !empty) check_result();
      // an item at the same edge still sees the old register value
      if (push && !full) parse_item(action, rx_byte, read_index);
      if (cfg_we) begin
        case (cfg_index)
          crcfr_pkg::CFG_HDR_FIRST:  sync_first  = cfg_data;
          crcfr_pkg::CFG_HDR_SECOND: sync_second = cfg_data;
          crcfr_pkg::CFG_TIMEOUT:    abort_ticks = cfg_data;
          default: ;
        endcase
      end
    end
    results_due <= results_q.size();
  end

endmodule

FILE: test/crc16_framed_packet_receiver_tb.sv
`timescale 1ns / 100ps
// Testbench top for crc16_framed_packet_receiver: drives bytes, ticks and payload reads
// in bursts across several header/timeout settings and gives the verdict.
// Depends on crcfr_pkg, the block and crc16_framed_packet_receiver_check.

module crc16_framed_packet_receiver_tb;

  localparam logic [1:0] ACT_UNUSED      = 2'd3;
  localparam int         ITEMS_PER_PHASE = 110;
  localparam int         HOLD_CYCLES     = 80;
  localparam int         SETTLE_CYCLES   = 8;
  localparam int         WATCHDOG_LIMIT  = 2000;

  logic        clk        = 1'b0;
  logic        rst        = 1'b1;
  logic        cfg_we     = 1'b0;
  logic [1:0]  cfg_index  = '0;
  logic [7:0]  cfg_data   = '0;
  logic        push       = 1'b0;
  logic [1:0]  action     = crcfr_pkg::ACT_BYTE;
  logic [7:0]  rx_byte    = '0;
  logic [7:0]  read_index = '0;
  logic        pop        = 1'b0;
  logic        full;
  logic        empty;
  logic        result_kind;
  logic [1:0]  frame_status;
  logic [7:0]  slave_address;
  logic [7:0]  function_code;
  logic [15:0] length_field;
  logic [15:0] crc_computed;
  logic [15:0] crc_received;
  logic [7:0]  read_data;
  int          fail_count;
  int          results_due;

  logic [7:0]  sync_first    = crcfr_pkg::RST_HDR_FIRST;
  logic [7:0]  sync_second   = crcfr_pkg::RST_HDR_SECOND;
  logic [7:0]  abort_ticks   = crcfr_pkg::RST_TIMEOUT;
  int          burst_left    = 0;
  int          items_sent    = 0;
  int          idle_cycles   = 0;
  bit          pressure_req  = 1'b0;
  bit          pressure_done = 1'b0;

  crc16_framed_packet_receiver i_dut (.*);

  crc16_framed_packet_receiver_check i_check (.*);

  always #6 clk = ~clk;

  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("crc16_framed_packet_receiver: mismatch");
      $finish;
    end
  end

  // result side: random stall modes, plus one long hold-off on request
  initial begin
    int mode;
    int mode_left;
    int hold_left;
    int beat;
    mode = 0;
    mode_left = 0;
    hold_left = 0;
    beat = 0;
    forever begin
      @(posedge clk);
      if (mode_left == 0) begin
        mode = $urandom_range(0, 3);
        mode_left = $urandom_range(20, 120);
      end
      mode_left--;
      beat++;
      if (pressure_req && !pressure_done) begin
        hold_left = HOLD_CYCLES;
        pressure_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else begin
        case (mode)
          0: pop <= 1'b1;
          1: pop <= $urandom_range(0, 1);
          2: pop <= (beat % 4 == 0);
          default: pop <= ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  task automatic offer(input logic [1:0] act, input logic [7:0] b, input logic [7:0] idx);
    if (burst_left == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                               : $urandom_range(1, 12);
    end
    push       <= 1'b1;
    action     <= act;
    rx_byte    <= b;
    read_index <= idx;
    do @(posedge clk); while (full);
    burst_left--;
    items_sent++;
  endtask

  task automatic send_byte(input logic [7:0] b);
    offer(crcfr_pkg::ACT_BYTE, b, $urandom_range(0, 255));
  endtask

  task automatic send_tick();
    offer(crcfr_pkg::ACT_TICK, $urandom_range(0, 255), $urandom_range(0, 255));
  endtask

  task automatic send_read(input logic [7:0] idx);
    offer(crcfr_pkg::ACT_READ, $urandom_range(0, 255), idx);
  endtask

  task automatic send_frame(input int len, input bit corrupt);
    logic [7:0]  body [$];
    logic [15:0] crc;
    int          n;
    body = {};
    body.push_back($urandom_range(0, 255));
    body.push_back(len[15:8]);
    body.push_back(len[7:0]);
    for (n = 0; n < len - 2; n++) body.push_back($urandom_range(0, 255));
    crc = crcfr_pkg::CRC_INIT;
    foreach (body[i]) crc = crcfr_pkg::crc_byte(crc, body[i]);
    if (corrupt) crc = crc ^ (16'h0001 << $urandom_range(0, 15));
    send_byte(sync_first);
    send_byte(sync_second);
    foreach (body[i]) begin
      send_byte(body[i]);
      // short tick runs that stay under the timeout
      if (abort_ticks > 1 && $urandom_range(0, 15) == 0)
        repeat ($urandom_range(1, (abort_ticks > 4) ? 3 : abort_ticks - 1)) send_tick();
    end
    send_byte(crc[15:8]);
    send_byte(crc[7:0]);
    send_byte($urandom_range(0, 255));
    send_byte($urandom_range(0, 255));
  endtask

  task automatic send_reject(input logic [15:0] len);
    send_byte(sync_first);
    send_byte(sync_second);
    send_byte($urandom_range(0, 255));
    send_byte(len[15:8]);
    send_byte(len[7:0]);
  endtask

  // timeout any partial frame, then a byte that cannot start or continue a header
  task automatic resync();
    logic [7:0] filler;
    repeat (abort_ticks) send_tick();
    do filler = $urandom_range(0, 255); while (filler == sync_first || filler == sync_second);
    send_byte(filler);
  endtask

  task automatic settle();
    push <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (results_due != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apply_settings(input logic [7:0] first, input logic [7:0] second,
                                input logic [7:0] ticks);
    settle();
    cfg_we    <= 1'b1;
    cfg_index <= crcfr_pkg::CFG_HDR_FIRST;
    cfg_data  <= first;
    @(posedge clk);
    cfg_index <= crcfr_pkg::CFG_HDR_SECOND;
    cfg_data  <= second;
    @(posedge clk);
    cfg_index <= crcfr_pkg::CFG_TIMEOUT;
    cfg_data  <= ticks;
    @(posedge clk);
    cfg_we <= 1'b0;
    sync_first  = first;
    sync_second = second;
    abort_ticks = ticks;
  endtask

  task automatic run_random(input int budget);
    int stop_at;
    int pick;
    stop_at = items_sent + budget;
    while (items_sent < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 55 || (pick >= 80 && abort_ticks > 40)) begin
        send_frame(($urandom_range(0, 6) == 0) ? $urandom_range(13, 60) : $urandom_range(3, 12),
                   $urandom_range(0, 3) == 0);
      end else if (pick < 65) begin
        repeat ($urandom_range(1, 4))
          send_read(($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 15));
      end else if (pick < 73) begin
        send_reject(($urandom_range(0, 2) == 0) ? $urandom_range(0, 2)
                                                : $urandom_range(256, 65535));
      end else if (pick < 80) begin
        repeat ($urandom_range(1, 3)) send_tick();
      end else if (pick < 90) begin
        // truncated frame with random bytes, rejected by its length field or aborted by the timeout
        send_byte(sync_first);
        send_byte(sync_second);
        repeat ($urandom_range(1, 20)) send_byte($urandom_range(0, 255));
        resync();
      end else begin
        repeat ($urandom_range(1, 8))
          offer($urandom_range(0, 3), $urandom_range(0, 255), $urandom_range(0, 255));
        resync();
      end
    end
  endtask

  initial begin
    logic [7:0] same_sync;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    send_read(8'h00);
    send_read(8'hFF);
    offer(ACT_UNUSED, 8'hFF, 8'hFF);
    send_tick();
    // wrong second sync equal to the first one, then the real second sync
    send_byte(sync_first);
    send_byte(sync_first);
    send_byte(sync_second);
    send_frame(3, 1'b0);
    send_reject(16'd2);

    pressure_req = 1'b1;
    repeat (16) send_read($urandom_range(0, 7));

    send_frame(255, 1'b0);
    run_random(ITEMS_PER_PHASE);
    apply_settings(8'h00, 8'hFF, 8'd1);
    run_random(ITEMS_PER_PHASE);
    apply_settings(8'hFF, 8'h00, 8'd255);
    run_random(ITEMS_PER_PHASE);
    apply_settings($urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(2, 40));
    run_random(ITEMS_PER_PHASE);
    same_sync = $urandom_range(0, 255);
    apply_settings(same_sync, same_sync, 8'd3);
    run_random(ITEMS_PER_PHASE);

    settle();
    if (fail_count == 0 && results_due == 0) begin
      $display("crc16_framed_packet_receiver: match");
    end else begin
      $display("crc16_framed_packet_receiver: mismatch");
    end
    $finish;
  end

endmodule

FILE: filelist.f
src/crcfr_pkg.sv
src/crcfr_front.sv
src/crcfr_queue.sv
src/crcfr_back.sv
src/crc16_framed_packet_receiver.sv
test/crc16_framed_packet_receiver_check.sv
test/crc16_framed_packet_receiver_tb.sv
